FILE: src/linear_constraint_classifier_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear constraint classifier
// Short forms for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LINEAR_CONSTRAINT_CLASSIFIER_MACROS_SVH
`define LINEAR_CONSTRAINT_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcc assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define LCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcc assertion failed");

`endif

FILE: src/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared constants, codes and types of the linear constraint classifier.
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int MAX_ELEMENTS = 4096;
    localparam int FRAC_BITS    = 16;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int OUT_CNT_W    = 13;
    localparam int VAL_W        = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
    localparam logic signed [VAL_W-1:0] ONE_Q = VAL_W'(64'sd1 <<< FRAC_BITS);

    typedef enum logic [1:0] {
        TYPE_CONT = 2'd0,
        TYPE_BIN  = 2'd1,
        TYPE_INT  = 2'd2
    } var_type_t;

    typedef enum logic [2:0] {
        SENSE_FREE  = 3'd0,
        SENSE_LE    = 3'd1,
        SENSE_GE    = 3'd2,
        SENSE_EQ    = 3'd3,
        SENSE_RANGE = 3'd4
    } sense_code_t;

    typedef enum logic [4:0] {
        CLS_EMPTY         = 5'd0,
        CLS_FREE          = 5'd1,
        CLS_SINGLETON     = 5'd2,
        CLS_AGGREGATION   = 5'd3,
        CLS_PRECEDENCE    = 5'd4,
        CLS_VAR_BOUND     = 5'd5,
        CLS_SET_PARTITION = 5'd6,
        CLS_SET_PACKING   = 5'd7,
        CLS_SET_COVERING  = 5'd8,
        CLS_CARDINALITY   = 5'd9,
        CLS_INV_KNAPSACK  = 5'd10,
        CLS_EQ_KNAPSACK   = 5'd11,
        CLS_BIN_PACKING   = 5'd12,
        CLS_KNAPSACK      = 5'd13,
        CLS_INT_KNAPSACK  = 5'd14,
        CLS_MIXED_BINARY  = 5'd15,
        CLS_GENERAL       = 5'd16
    } class_code_t;

    // One input item as held in the input register
    typedef struct packed {
        logic                    has_element;
        logic [1:0]              var_type;
        logic signed [VAL_W-1:0] coefficient;
        logic signed [VAL_W-1:0] lower_limit;
        logic signed [VAL_W-1:0] upper_limit;
        logic                    lower_infinite;
        logic                    upper_infinite;
        logic                    last;
    } lcc_item_t;

    // Running statistics of the constraint under way
    typedef struct packed {
        logic [CNT_W-1:0] elem_cnt;
        logic [CNT_W-1:0] bin_cnt;
        logic [CNT_W-1:0] int_cnt;
        var_type_t        first_type;
        var_type_t        second_type;
        logic             all_ones;
        logic             coef_eq_ub;
    } lcc_stats_t;

    localparam lcc_stats_t STATS_CLEAR = '{
        elem_cnt:    '0,
        bin_cnt:     '0,
        int_cnt:     '0,
        first_type:  TYPE_CONT,
        second_type: TYPE_CONT,
        all_ones:    1'b1,
        coef_eq_ub:  1'b0
    };

    // One result item
    typedef struct packed {
        logic [OUT_CNT_W-1:0] integer_count;
        logic [OUT_CNT_W-1:0] binary_count;
        logic [OUT_CNT_W-1:0] variable_count;
        sense_code_t          sense_code;
        class_code_t          class_code;
    } lcc_result_t;

endpackage

FILE: src/lcc_accum.sv
// ----------------------------------------------------------------------------
// lcc_accum
// Per-constraint accumulators: saturating counts, first two types and the
// coefficient flags; cleared after the closing item.
// ----------------------------------------------------------------------------
module lcc_accum
    import lcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lcc_item_t  item,
    input  logic       advance,      // item leaves the input register
    output lcc_stats_t stats,        // state before this item
    output lcc_stats_t stats_upd     // state including this item
);

    lcc_stats_t stats_reg;
    lcc_stats_t stats_next;
    var_type_t  vt;

    always_comb
    begin
        case (item.var_type)
            TYPE_BIN: vt = TYPE_BIN;
            TYPE_INT: vt = TYPE_INT;
            default:  vt = TYPE_CONT;
        endcase
    end

    always_comb
    begin
        stats_upd = stats_reg;
        if (item.has_element)
        begin
            if (stats_reg.elem_cnt == '0)
                stats_upd.first_type = vt;
            else if (stats_reg.elem_cnt == CNT_W'(1))
                stats_upd.second_type = vt;
            if (stats_reg.elem_cnt < CNT_MAX)
                stats_upd.elem_cnt = stats_reg.elem_cnt + CNT_W'(1);
            if (vt == TYPE_BIN && stats_reg.bin_cnt < CNT_MAX)
                stats_upd.bin_cnt = stats_reg.bin_cnt + CNT_W'(1);
            if (vt == TYPE_INT && stats_reg.int_cnt < CNT_MAX)
                stats_upd.int_cnt = stats_reg.int_cnt + CNT_W'(1);
            if (item.coefficient != ONE_Q)
                stats_upd.all_ones = 1'b0;
            if (!item.upper_infinite && item.coefficient == item.upper_limit)
                stats_upd.coef_eq_ub = 1'b1;
        end
    end

    always_comb
    begin
        stats_next = stats_reg;
        if (advance)
            stats_next = item.last ? STATS_CLEAR : stats_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stats_reg <= STATS_CLEAR;
        else
            stats_reg <= stats_next;
    end

    assign stats = stats_reg;

endmodule

FILE: src/lcc_classify.sv
// ----------------------------------------------------------------------------
// lcc_classify
// Sense and class decision for a closed constraint.
// ----------------------------------------------------------------------------
module lcc_classify
    import lcc_pkg::*;
(
    input  lcc_item_t   item,
    input  lcc_stats_t  stats,
    output lcc_result_t result
);

    sense_code_t sense;
    class_code_t cls;
    logic        lb_one;
    logic        ub_one;
    logic        all_bin;
    logic        bin_or_int;
    logic        n_zero;
    logic        n_one;
    logic        n_two;
    logic        ones_bin;

    always_comb
    begin
        if (item.lower_infinite && item.upper_infinite)
            sense = SENSE_FREE;
        else if (item.lower_infinite)
            sense = SENSE_LE;
        else if (item.upper_infinite)
            sense = SENSE_GE;
        else if (item.lower_limit == item.upper_limit)
            sense = SENSE_EQ;
        else
            sense = SENSE_RANGE;
    end

    assign lb_one     = !item.lower_infinite && item.lower_limit == ONE_Q;
    assign ub_one     = !item.upper_infinite && item.upper_limit == ONE_Q;
    assign all_bin    = stats.bin_cnt == stats.elem_cnt;
    assign bin_or_int = ((CNT_W+1)'(stats.bin_cnt) + (CNT_W+1)'(stats.int_cnt))
                        == (CNT_W+1)'(stats.elem_cnt);
    assign n_zero     = stats.elem_cnt == '0;
    assign n_one      = stats.elem_cnt == CNT_W'(1);
    assign n_two      = stats.elem_cnt == CNT_W'(2);
    assign ones_bin   = stats.all_ones && all_bin;

    always_comb
    begin
        if (n_zero)
            cls = CLS_EMPTY;
        else if (sense == SENSE_FREE)
            cls = CLS_FREE;
        else if (n_one)
            cls = CLS_SINGLETON;
        else if (sense == SENSE_EQ && n_two)
            cls = CLS_AGGREGATION;
        else if (n_two && sense != SENSE_RANGE && stats.first_type == stats.second_type)
            cls = CLS_PRECEDENCE;
        else if (n_two && sense != SENSE_RANGE
                 && (stats.first_type == TYPE_BIN || stats.second_type == TYPE_BIN))
            cls = CLS_VAR_BOUND;
        else if (lb_one && ub_one && ones_bin)
            cls = CLS_SET_PARTITION;
        else if (sense == SENSE_LE && ub_one && ones_bin)
            cls = CLS_SET_PACKING;
        else if (sense == SENSE_GE && lb_one && ones_bin)
            cls = CLS_SET_COVERING;
        else if (sense == SENSE_EQ && ones_bin)
            cls = CLS_CARDINALITY;
        else if (sense == SENSE_LE && ones_bin)
            cls = CLS_INV_KNAPSACK;
        else if (sense == SENSE_EQ && all_bin)
            cls = CLS_EQ_KNAPSACK;
        else if (sense == SENSE_LE && all_bin && stats.coef_eq_ub)
            cls = CLS_BIN_PACKING;
        else if (sense == SENSE_LE && all_bin)
            cls = CLS_KNAPSACK;
        else if (sense == SENSE_LE && bin_or_int)
            cls = CLS_INT_KNAPSACK;
        else if (stats.int_cnt == '0)
            cls = CLS_MIXED_BINARY;
        else
            cls = CLS_GENERAL;
    end

    always_comb
    begin
        result.class_code     = cls;
        result.sense_code     = sense;
        result.variable_count = OUT_CNT_W'(stats.elem_cnt);
        result.binary_count   = OUT_CNT_W'(stats.bin_cnt);
        result.integer_count  = OUT_CNT_W'(stats.int_cnt);
    end

endmodule

FILE: src/linear_constraint_classifier.sv
// ----------------------------------------------------------------------------
// linear_constraint_classifier
// Streams the elements of one linear constraint and emits its sense and class.
// ----------------------------------------------------------------------------
// Feed one item per element of a constraint, with tlast on the final one; an
// empty constraint is a single item with tuser (has_element) low and tlast
// high, and an item with tuser low and tlast low is ignored. Each item is
// captured in an input register, then the accumulator update and, for a
// closing item, the sense and class decision run in one pass into the result
// register. The block takes an item every cycle, also while a result waits
// on the master side; only a closing item waits for that result to be taken.
// A closing item passes the input register, then the result register. Counts
// saturate at MAX_ELEMENTS and are reported on 13 bits. The bounds and
// infinity flags used for the sense are those of the closing item.
// ----------------------------------------------------------------------------
`include "linear_constraint_classifier_macros.svh"

module linear_constraint_classifier
    import lcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // Element stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata from bit 0: var_type[1:0], coefficient[33:2], lower_limit[65:34],
    // upper_limit[97:66], lower_infinite[98], upper_infinite[99], zeros[103:100]
    input  logic [103:0] s_axis_tdata,
    // tuser: has_element
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata from bit 0: class_code[4:0], sense_code[7:5], variable_count[20:8],
    // binary_count[33:21], integer_count[46:34], zero[47]
    output logic [47:0]  m_axis_tdata
);

    // Input register
    logic        in_valid_reg;
    logic        in_valid_next;
    lcc_item_t   in_item_reg;

    // Result register
    logic        out_valid_reg;
    logic        out_valid_next;
    lcc_result_t out_result_reg;

    logic        out_free;
    logic        advance;
    logic        s_fire;
    lcc_item_t   in_item;
    lcc_stats_t  stats;
    lcc_stats_t  stats_upd;
    lcc_result_t result;

    // Unpack the incoming item
    always_comb
    begin
        in_item.has_element    = s_axis_tuser;
        in_item.var_type       = s_axis_tdata[1:0];
        in_item.coefficient    = s_axis_tdata[33:2];
        in_item.lower_limit    = s_axis_tdata[65:34];
        in_item.upper_limit    = s_axis_tdata[97:66];
        in_item.lower_infinite = s_axis_tdata[98];
        in_item.upper_infinite = s_axis_tdata[99];
        in_item.last           = s_axis_tlast;
    end

    // The result slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    // Advance the held item; a closing item needs the result slot
    assign advance = in_valid_reg && (!in_item_reg.last || out_free);

    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && in_item_reg.last)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold until replaced
    always_ff @(posedge clk)
    begin
        if (s_fire)
            in_item_reg <= in_item;
        if (advance && in_item_reg.last)
            out_result_reg <= result;
    end

    lcc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_item_reg),
        .advance   (advance),
        .stats     (stats),
        .stats_upd (stats_upd)
    );

    lcc_classify u_classify (
        .item   (in_item_reg),
        .stats  (stats_upd),
        .result (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_result_reg};

    // A result reports Empty exactly when it counted no element
    `LCC_ASSERT_NOW(a_empty_iff_zero, clk, rst_n, out_valid_reg,
        (out_result_reg.class_code == CLS_EMPTY) == (out_result_reg.variable_count == '0))

    // Accumulators are cleared once a closing item has been taken
    `LCC_ASSERT_NEXT(a_clear_after_close, clk, rst_n, advance && in_item_reg.last,
        stats == STATS_CLEAR)

    // Typed counts never exceed the element count
    `LCC_ASSERT_NOW(a_counts_bounded, clk, rst_n, 1'b1,
        (stats.bin_cnt <= stats.elem_cnt) && (stats.int_cnt <= stats.elem_cnt))

    // A closing item never overwrites a result still waiting on the master side
    `LCC_ASSERT_NOW(a_no_overwrite, clk, rst_n, advance && in_item_reg.last, out_free)

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the linear constraint classifier
// Streams whole constraints into the block and predicts each closing result:
// sense, class and the three counts. The results that come back are checked
// field by field against the oldest prediction. The run covers empty and
// ignored items, every class, the unused type code, coefficients that match
// an infinite upper bound, and then random constraints.
// Random idle bursts fall on both sides of the block.
// ----------------------------------------------------------------------------
module testbench;
    import lcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 850;

    // Type code that has no meaning; the block must fold it into continuous
    localparam logic [1:0] TYPE_UNUSED = 2'd3;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata  = '0;
    logic         s_axis_tuser  = 1'b0;
    logic         s_axis_tlast  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [47:0]  m_axis_tdata;

    // Bounds carried by every item of the constraint under way
    logic signed [VAL_W-1:0] bnd_lower     = '0;
    logic signed [VAL_W-1:0] bnd_upper     = '0;
    logic                    bnd_lower_inf = 1'b0;
    logic                    bnd_upper_inf = 1'b0;

    // Running statistics of the predicted constraint
    int unsigned acc_elems;
    int unsigned acc_bins;
    int unsigned acc_ints;
    logic [1:0]  acc_first;
    logic [1:0]  acc_second;
    bit          acc_all_ones;
    bit          acc_coef_ub;

    lcc_result_t expected_results[$];
    int          error_count   = 0;
    int          results_seen  = 0;
    int          idle_cycles   = 0;
    bit          idle_on       = 1'b1;

    always #4 clk = ~clk;

    linear_constraint_classifier uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic logic signed [VAL_W-1:0] q16(input int value);
        return VAL_W'(value) <<< FRAC_BITS;
    endfunction

    function automatic void clear_accumulators();
        acc_elems    = 0;
        acc_bins     = 0;
        acc_ints     = 0;
        acc_first    = TYPE_CONT;
        acc_second   = TYPE_CONT;
        acc_all_ones = 1'b1;
        acc_coef_ub  = 1'b0;
    endfunction

    function automatic int unsigned sat_increment(input int unsigned count);
        return (count < MAX_ELEMENTS) ? count + 1 : count;
    endfunction

    // Decide the class from the accumulated statistics; order of tests matters
    function automatic class_code_t classify_constraint(input sense_code_t sense,
                                                        input bit lb_one,
                                                        input bit ub_one);
        bit all_bin;
        all_bin = (acc_bins == acc_elems);
        if (acc_elems == 0)
            return CLS_EMPTY;
        if (sense == SENSE_FREE)
            return CLS_FREE;
        if (acc_elems == 1)
            return CLS_SINGLETON;
        if (sense == SENSE_EQ && acc_elems == 2)
            return CLS_AGGREGATION;
        if (acc_elems == 2 && sense != SENSE_RANGE)
        begin
            if (acc_first == acc_second)
                return CLS_PRECEDENCE;
            if (acc_first == TYPE_BIN || acc_second == TYPE_BIN)
                return CLS_VAR_BOUND;
        end
        if (lb_one && ub_one && acc_all_ones && all_bin)
            return CLS_SET_PARTITION;
        if (sense == SENSE_LE && ub_one && acc_all_ones && all_bin)
            return CLS_SET_PACKING;
        if (sense == SENSE_GE && lb_one && acc_all_ones && all_bin)
            return CLS_SET_COVERING;
        if (sense == SENSE_EQ && acc_all_ones && all_bin)
            return CLS_CARDINALITY;
        if (sense == SENSE_LE && acc_all_ones && all_bin)
            return CLS_INV_KNAPSACK;
        if (sense == SENSE_EQ && all_bin)
            return CLS_EQ_KNAPSACK;
        if (sense == SENSE_LE && all_bin && acc_coef_ub)
            return CLS_BIN_PACKING;
        if (sense == SENSE_LE && all_bin)
            return CLS_KNAPSACK;
        if (sense == SENSE_LE && acc_bins + acc_ints == acc_elems)
            return CLS_INT_KNAPSACK;
        if (acc_ints == 0)
            return CLS_MIXED_BINARY;
        return CLS_GENERAL;
    endfunction

    // Fold one accepted item into the statistics; queue a result on a closing item
    function automatic void predict_item(input lcc_item_t it);
        logic [1:0]  vt;
        sense_code_t sense;
        lcc_result_t res;
        vt = (it.var_type == TYPE_UNUSED) ? TYPE_CONT : it.var_type;
        if (it.has_element)
        begin
            if (acc_elems == 0)
                acc_first = vt;
            else if (acc_elems == 1)
                acc_second = vt;
            acc_elems = sat_increment(acc_elems);
            if (vt == TYPE_BIN)
                acc_bins = sat_increment(acc_bins);
            else if (vt == TYPE_INT)
                acc_ints = sat_increment(acc_ints);
            if (it.coefficient != ONE_Q)
                acc_all_ones = 1'b0;
            if (!it.upper_infinite && it.coefficient == it.upper_limit)
                acc_coef_ub = 1'b1;
        end
        if (!it.last)
            return;
        if (it.lower_infinite && it.upper_infinite)
            sense = SENSE_FREE;
        else if (it.lower_infinite)
            sense = SENSE_LE;
        else if (it.upper_infinite)
            sense = SENSE_GE;
        else if (it.lower_limit == it.upper_limit)
            sense = SENSE_EQ;
        else
            sense = SENSE_RANGE;
        res.class_code     = classify_constraint(sense,
                                 !it.lower_infinite && it.lower_limit == ONE_Q,
                                 !it.upper_infinite && it.upper_limit == ONE_Q);
        res.sense_code     = sense;
        res.variable_count = OUT_CNT_W'(acc_elems);
        res.binary_count   = OUT_CNT_W'(acc_bins);
        res.integer_count  = OUT_CNT_W'(acc_ints);
        expected_results.insert(expected_results.size(), res);
        clear_accumulators();
    endfunction

    function automatic lcc_item_t make_item(input logic has, input logic [1:0] vt,
                                            input logic signed [VAL_W-1:0] coef,
                                            input logic last);
        lcc_item_t it;
        it.has_element    = has;
        it.var_type       = vt;
        it.coefficient    = coef;
        it.lower_limit    = bnd_lower;
        it.upper_limit    = bnd_upper;
        it.lower_infinite = bnd_lower_inf;
        it.upper_infinite = bnd_upper_inf;
        it.last           = last;
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at result %0d: %s is %0d, expected %0d",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // Present one item from a falling edge and hold it until accepted
    task automatic send_item(input lcc_item_t it);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.has_element;
        s_axis_tlast  = it.last;
        s_axis_tdata  = {4'b0000, it.upper_infinite, it.lower_infinite, it.upper_limit,
                         it.lower_limit, it.coefficient, it.var_type};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_item(it);
        @(negedge clk);
    endtask

    task automatic set_bounds(input logic signed [VAL_W-1:0] lower,
                              input logic signed [VAL_W-1:0] upper,
                              input logic lower_inf, input logic upper_inf);
        bnd_lower     = lower;
        bnd_upper     = upper;
        bnd_lower_inf = lower_inf;
        bnd_upper_inf = upper_inf;
    endtask

    task automatic send_element(input logic [1:0] vt, input logic signed [VAL_W-1:0] coef,
                                input logic last);
        send_item(make_item(1'b1, vt, coef, last));
    endtask

    // Send count equal elements; mark the final one as last when asked
    task automatic send_run(input int count, input logic [1:0] vt,
                            input logic signed [VAL_W-1:0] coef, input bit close);
        for (int i = 0; i < count; i++)
            send_element(vt, coef, close && i == count - 1);
    endtask

    // Empty constraints under every sense, and items that carry nothing
    task automatic test_empty_and_ignored();
        set_bounds(q16(0), q16(0), 1'b1, 1'b1);
        send_item(make_item(1'b0, TYPE_CONT, '0, 1'b1));
        set_bounds(q16(0), q16(4), 1'b1, 1'b0);
        send_item(make_item(1'b0, TYPE_BIN, ONE_Q, 1'b1));
        set_bounds(q16(-3), q16(4), 1'b0, 1'b1);
        send_item(make_item(1'b0, TYPE_INT, ONE_Q, 1'b1));
        set_bounds(ONE_Q, ONE_Q, 1'b0, 1'b0);
        send_item(make_item(1'b0, TYPE_UNUSED, ONE_Q, 1'b1));
        set_bounds(q16(-1), ONE_Q, 1'b0, 1'b0);
        send_item(make_item(1'b0, TYPE_CONT, q16(7), 1'b1));
        // Ignored items must not open, count or close anything
        send_item(make_item(1'b0, TYPE_BIN, ONE_Q, 1'b0));
        send_element(TYPE_BIN, ONE_Q, 1'b0);
        send_item(make_item(1'b0, TYPE_INT, q16(2), 1'b0));
        send_element(TYPE_INT, q16(2), 1'b0);
        // Close with an item that carries no element
        send_item(make_item(1'b0, TYPE_CONT, '0, 1'b1));
    endtask

    // Classes decided by sense and the first two types
    task automatic test_short_classes();
        set_bounds(q16(0), q16(0), 1'b1, 1'b1);
        send_element(TYPE_BIN, ONE_Q, 1'b1);
        set_bounds(q16(0), q16(5), 1'b1, 1'b0);
        send_element(TYPE_INT, q16(3), 1'b1);
        set_bounds(q16(2), q16(2), 1'b0, 1'b0);
        send_element(TYPE_CONT, q16(1), 1'b0);
        send_element(TYPE_INT, q16(-1), 1'b1);
        set_bounds(q16(0), q16(0), 1'b1, 1'b0);
        send_element(TYPE_INT, q16(1), 1'b0);
        send_element(TYPE_INT, q16(-1), 1'b1);
        set_bounds(q16(0), q16(0), 1'b0, 1'b1);
        send_element(TYPE_BIN, q16(-4), 1'b0);
        send_element(TYPE_CONT, q16(1), 1'b1);
        // Two elements under a range fall through to the late classes
        set_bounds(q16(-2), q16(6), 1'b0, 1'b0);
        send_element(TYPE_INT, q16(1), 1'b0);
        send_element(TYPE_CONT, q16(1), 1'b1);
        send_element(TYPE_BIN, q16(1), 1'b0);
        send_element(TYPE_CONT, q16(1), 1'b1);
        // The unused type code behaves as continuous
        set_bounds(q16(0), q16(3), 1'b1, 1'b0);
        send_element(TYPE_UNUSED, q16(1), 1'b0);
        send_element(TYPE_CONT, q16(2), 1'b1);
        send_element(TYPE_UNUSED, q16(1), 1'b0);
        send_element(TYPE_BIN, q16(2), 1'b1);
        send_element(TYPE_UNUSED, ONE_Q, 1'b1);
    endtask

    // Pure binary constraints, one per class from set partitioning to knapsack
    task automatic test_binary_classes();
        set_bounds(ONE_Q, ONE_Q, 1'b0, 1'b0);
        send_run(3, TYPE_BIN, ONE_Q, 1'b1);
        set_bounds(q16(0), ONE_Q, 1'b1, 1'b0);
        send_run(3, TYPE_BIN, ONE_Q, 1'b1);
        set_bounds(ONE_Q, q16(0), 1'b0, 1'b1);
        send_run(3, TYPE_BIN, ONE_Q, 1'b1);
        set_bounds(q16(2), q16(2), 1'b0, 1'b0);
        send_run(3, TYPE_BIN, ONE_Q, 1'b1);
        set_bounds(q16(0), q16(2), 1'b1, 1'b0);
        send_run(3, TYPE_BIN, ONE_Q, 1'b1);
        set_bounds(q16(3), q16(3), 1'b0, 1'b0);
        send_run(3, TYPE_BIN, q16(2), 1'b1);
        set_bounds(q16(0), q16(3), 1'b1, 1'b0);
        send_element(TYPE_BIN, q16(1), 1'b0);
        send_element(TYPE_BIN, q16(3), 1'b0);
        send_element(TYPE_BIN, q16(2), 1'b1);
        set_bounds(q16(0), q16(5), 1'b1, 1'b0);
        send_run(3, TYPE_BIN, q16(2), 1'b1);
    endtask

    // Mixed types, extreme values and a coefficient matching an infinite bound
    task automatic test_mixed_and_extremes();
        set_bounds(q16(0), q16(7), 1'b1, 1'b0);
        send_element(TYPE_BIN, q16(2), 1'b0);
        send_element(TYPE_INT, q16(3), 1'b0);
        send_element(TYPE_BIN, q16(1), 1'b1);
        set_bounds(q16(1), q16(0), 1'b0, 1'b1);
        send_element(TYPE_BIN, q16(2), 1'b0);
        send_element(TYPE_CONT, q16(3), 1'b0);
        send_element(TYPE_BIN, q16(1), 1'b1);
        set_bounds(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b0);
        send_element(TYPE_INT, 32'sh8000_0000, 1'b0);
        send_element(TYPE_UNUSED, 32'sh7FFF_FFFF, 1'b0);
        send_element(TYPE_CONT, 32'shFFFF_FFFF, 1'b1);
        // Upper bound flagged infinite while the coefficient matches its value
        set_bounds(q16(0), q16(3), 1'b1, 1'b1);
        send_element(TYPE_BIN, q16(3), 1'b0);
        send_element(TYPE_BIN, q16(3), 1'b0);
        bnd_upper_inf = 1'b0;
        send_element(TYPE_BIN, q16(2), 1'b1);
        // A one that is hidden behind an infinity flag does not count
        set_bounds(ONE_Q, ONE_Q, 1'b1, 1'b0);
        send_run(3, TYPE_BIN, ONE_Q, 1'b1);
    endtask

    // Hold the sender until every expected result has arrived
    task automatic test_drain_pause();
        s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        set_bounds(q16(0), q16(0), 1'b1, 1'b1);
        send_element(TYPE_BIN, ONE_Q, 1'b1);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_bound();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ONE_Q;
            2: return q16($urandom_range(2, 9));
            3: return -q16($urandom_range(1, 9));
            4: return 32'sh8000_0000;
            5: return 32'sh7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_type();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return TYPE_BIN;
        if (pick < 7)
            return TYPE_INT;
        if (pick < 9)
            return TYPE_CONT;
        return TYPE_UNUSED;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_coefficient();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return ONE_Q;
            4: return bnd_upper;
            5: return q16($urandom_range(2, 5));
            default: return $urandom;
        endcase
    endfunction

    // One well-formed constraint with random content, with a little noise
    task automatic random_constraint(inout int sent);
        int len;
        int pick;
        bit split_close;
        bnd_lower     = pick_bound();
        bnd_upper     = ($urandom_range(0, 2) == 0) ? bnd_lower : pick_bound();
        bnd_lower_inf = ($urandom_range(0, 3) == 0);
        bnd_upper_inf = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 19);
        if (pick == 0)
            len = 0;
        else if (pick < 15)
            len = $urandom_range(1, 5);
        else
            len = $urandom_range(6, 24);
        split_close = (len == 0) || ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 14) == 0)
            begin
                send_item(make_item(1'b0, 2'($urandom), VAL_W'($urandom), 1'b0));
                sent++;
            end
            // Now and then the closing item brings bounds of its own
            if (i == len - 1 && $urandom_range(0, 15) == 0)
            begin
                bnd_lower     = pick_bound();
                bnd_lower_inf = 1'($urandom);
                bnd_upper_inf = 1'($urandom);
            end
            send_element(pick_type(), pick_coefficient(), !split_close && i == len - 1);
            sent++;
        end
        if (split_close)
        begin
            send_item(make_item(1'b0, 2'($urandom), VAL_W'($urandom), 1'b1));
            sent++;
        end
    endtask

    task automatic test_random_constraints(input int target, input bit quiet_tail);
        int sent;
        sent = 0;
        while (sent < target)
        begin
            // Drop all idling for the tail of the run
            if (quiet_tail && sent >= target * 2 / 3)
                idle_on = 1'b0;
            random_constraint(sent);
        end
    endtask

    // Receiver: random stall bursts while idling is on, otherwise always ready
    initial
    begin
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall == 0 && idle_on && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 7);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                stall--;
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        lcc_result_t got;
        lcc_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[46:0];
            if (expected_results.size() == 0)
                report_mismatch("result with nothing outstanding, class",
                                32'(got.class_code), 0);
            else
            begin
                want = expected_results.pop_front();
                if (got.class_code != want.class_code)
                    report_mismatch("class_code", 32'(got.class_code),
                                    32'(want.class_code));
                if (got.sense_code != want.sense_code)
                    report_mismatch("sense_code", 32'(got.sense_code),
                                    32'(want.sense_code));
                if (got.variable_count != want.variable_count)
                    report_mismatch("variable_count", 32'(got.variable_count),
                                    32'(want.variable_count));
                if (got.binary_count != want.binary_count)
                    report_mismatch("binary_count", 32'(got.binary_count),
                                    32'(want.binary_count));
                if (got.integer_count != want.integer_count)
                    report_mismatch("integer_count", 32'(got.integer_count),
                                    32'(want.integer_count));
                if (m_axis_tdata[47] != 1'b0)
                    report_mismatch("padding bit", 32'(m_axis_tdata[47]), 0);
            end
            results_seen++;
        end
    end

    // End the run when nothing is accepted on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL linear_constraint_classifier");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        clear_accumulators();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_empty_and_ignored();
        test_short_classes();
        test_binary_classes();
        test_mixed_and_extremes();
        test_random_constraints(RANDOM_ITEMS, 1'b0);
        test_drain_pause();
        test_random_constraints(RANDOM_ITEMS, 1'b1);
        s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS linear_constraint_classifier");
        else
            $display("FAIL linear_constraint_classifier");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/lcc_pkg.sv
src/lcc_accum.sv
src/lcc_classify.sv
src/linear_constraint_classifier.sv
sim/testbench.sv
